/* src/crc16_command_frame_engine_top_defines.svh */
// assertion macros for the crc16 command frame engine
`ifndef CRC16_COMMAND_FRAME_ENGINE_TOP_DEFINES_SVH
`define CRC16_COMMAND_FRAME_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CRC16FE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crc16fe check failed");
`define CRC16FE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crc16fe check failed");
`else
`define CRC16FE_ASSERT_IMP(label, clk, rst, ante, cons)
`define CRC16FE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/crc16fe_pkg.sv */
// shared types, constants and crc function for the crc16 command frame engine
`default_nettype none
package crc16fe_pkg;

   localparam int DATA_W      = 8;
   localparam int CRC_W       = 16;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h8005;
   localparam logic [DATA_W-1:0] MAX_FRAME_RST = 8'd35;
   localparam logic [DATA_W-1:0] MIN_COUNT     = 8'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_DIRECTION = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_FRAME = CSR_INDEX_W'(1);

   localparam logic DIR_TX = 1'b0;
   localparam logic DIR_RX = 1'b1;

   localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CRC_BAD   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_COUNT_LOW = 3'd4;

   localparam logic [1:0] BEAT_ECHO   = 2'd0;
   localparam logic [1:0] BEAT_CRC_LO = 2'd1;
   localparam logic [1:0] BEAT_CRC_HI = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              end_of_payload;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   out_byte;
      logic                run_last;
      logic [STATUS_W-1:0] frame_status;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data_byte;
      logic                append_crc;
      logic [CRC_W-1:0]    crc;
      logic [STATUS_W-1:0] status;
   } frame_op_type;

   typedef struct packed {
      logic         valid;
      frame_op_type op;
   } op_beat_type;

   function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc;
      for (int i = 0; i < DATA_W; i++) begin
         if (b[i] != c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* src/crc16_command_frame_engine_top.sv */
// top level of the crc16 command frame engine
//
//   port group  dir  handshake              beat contents
//   req_*       in   req_valid/req_ready    data_byte, end_of_payload
//   rsp_*       out  rsp_valid/rsp_ready    out_byte, run_last, frame_status
//   csr_*       in   csr_we                 register index, write data
//
// one input beat per cycle is taken while the operation queue has room
// each accepted beat gives one result beat, three in transmit on end of payload
// the result port moves one beat per cycle unless rsp_ready stalls it
// four-entry queue lets the front keep taking beats while the back drains crc bytes
// synchronous reset; no clearing pass, the block is ready the cycle after reset
`default_nettype none
module crc16_command_frame_engine_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [crc16fe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [crc16fe_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire crc16fe_pkg::req_type                  req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output crc16fe_pkg::rsp_type                       rsp_data
);
   import crc16fe_pkg::*;

   op_beat_type  push;
   logic         q_full;
   logic         pop;
   logic         head_valid;
   frame_op_type head;

   crc16fe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   crc16fe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   crc16fe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

/* src/crc16fe_front.sv */
// front end: config registers, crc update and frame classification per beat
`default_nettype none
`include "crc16_command_frame_engine_top_defines.svh"
module crc16fe_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [crc16fe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [crc16fe_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire crc16fe_pkg::req_type                  req_data,
   input  wire logic                                  q_full,
   output crc16fe_pkg::op_beat_type                   push
);
   import crc16fe_pkg::*;

   logic              dir_ff, dir_in;
   logic [DATA_W-1:0] max_ff, max_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [DATA_W-1:0] pos_ff, pos_in;
   logic [DATA_W-1:0] cnt_ff, cnt_in;
   logic              mis_ff, mis_in;

   logic                accept;
   logic [CRC_W-1:0]    crc_next;
   logic [DATA_W:0]     pos_plus2;
   logic [STATUS_W-1:0] status;
   logic                mismatch;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign crc_next  = crc16_feed(crc_ff, req_data.data_byte);
   assign pos_plus2 = {1'b0, pos_ff} + (DATA_W+1)'(2);

   always_comb begin
      dir_in   = dir_ff;
      max_in   = max_ff;
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      mis_in   = mis_ff;
      status   = ST_BUSY;
      mismatch = mis_ff;

      push.valid         = accept;
      push.op.data_byte  = req_data.data_byte;
      push.op.append_crc = 1'b0;
      push.op.crc        = crc_next;
      push.op.status     = ST_BUSY;

      if (accept) begin
         if (dir_ff == DIR_TX) begin
            push.op.append_crc = req_data.end_of_payload;
            crc_in = req_data.end_of_payload ? '0 : crc_next;
         end else begin
            if (pos_ff == '0) begin
               if (req_data.data_byte < MIN_COUNT) begin
                  status = ST_COUNT_LOW;
               end else begin
                  cnt_in = req_data.data_byte;
                  crc_in = crc_next;
                  pos_in = DATA_W'(1);
               end
            end else if (pos_ff >= max_ff) begin
               status = ST_OVERFLOW;
            end else if (pos_plus2 < {1'b0, cnt_ff}) begin
               crc_in = crc_next;
               pos_in = pos_ff + 1'b1;
            end else if (pos_plus2 == {1'b0, cnt_ff}) begin
               if (req_data.data_byte != crc_ff[7:0]) begin
                  mis_in = 1'b1;
               end
               pos_in = pos_ff + 1'b1;
            end else begin
               mismatch = mis_ff || (req_data.data_byte != crc_ff[15:8]);
               status   = mismatch ? ST_CRC_BAD : ST_OK;
            end
            if (status != ST_BUSY) begin
               crc_in = '0;
               pos_in = '0;
               cnt_in = '0;
               mis_in = 1'b0;
            end
            push.op.status = status;
         end
      end

      if (csr_we) begin
         case (csr_index)
            REG_DIRECTION: begin
               dir_in = csr_wdata[0];
               crc_in = '0;
               pos_in = '0;
               cnt_in = '0;
               mis_in = 1'b0;
            end
            REG_MAX_FRAME: begin
               max_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_TX;
         max_ff <= MAX_FRAME_RST;
         crc_ff <= '0;
         pos_ff <= '0;
         cnt_ff <= '0;
         mis_ff <= 1'b0;
      end else begin
         dir_ff <= dir_in;
         max_ff <= max_in;
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         mis_ff <= mis_in;
      end
   end

   `CRC16FE_ASSERT_NXT(a_frame_end_clears, clock, reset, accept && dir_ff == DIR_RX && status != ST_BUSY && !csr_we, pos_ff == '0 && crc_ff == '0 && !mis_ff)
   `CRC16FE_ASSERT_IMP(a_tx_no_position, clock, reset, dir_ff == DIR_TX, pos_ff == '0 && cnt_ff == '0)

endmodule
`default_nettype wire

/* src/crc16fe_queue.sv */
// short fifo of classified operations between front and back
`default_nettype none
`include "crc16_command_frame_engine_top_defines.svh"
module crc16fe_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire crc16fe_pkg::op_beat_type      push,
   output logic                               full,
   input  wire logic                          pop,
   output logic                               head_valid,
   output crc16fe_pkg::frame_op_type          head
);
   import crc16fe_pkg::*;

   frame_op_type      slots_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slots_ff[rd_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push.op;
      end
   end

   `CRC16FE_ASSERT_IMP(a_no_overrun, clock, reset, push.valid, !full)
   `CRC16FE_ASSERT_IMP(a_no_underrun, clock, reset, pop, head_valid)

endmodule
`default_nettype wire

/* src/crc16fe_back.sv */
// back end: expands each operation into result beats behind an output register
`default_nettype none
`include "crc16_command_frame_engine_top_defines.svh"
module crc16fe_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire crc16fe_pkg::frame_op_type     head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output crc16fe_pkg::rsp_type               rsp_data
);
   import crc16fe_pkg::*;

   logic [1:0] beat_ff, beat_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic       load;
   rsp_type    sel;

   assign load = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      sel.frame_status = head.status;
      sel.out_byte     = head.data_byte;
      sel.run_last     = 1'b1;
      if (head.append_crc) begin
         case (beat_ff)
            BEAT_ECHO: begin
               sel.out_byte = head.data_byte;
               sel.run_last = 1'b0;
            end
            BEAT_CRC_LO: begin
               sel.out_byte = head.crc[7:0];
               sel.run_last = 1'b0;
            end
            BEAT_CRC_HI: begin
               sel.out_byte = head.crc[15:8];
               sel.run_last = 1'b1;
            end
            default: begin
               sel.out_byte = head.data_byte;
               sel.run_last = 1'b1;
            end
         endcase
      end

      pop      = load && sel.run_last;
      beat_in  = beat_ff;
      if (pop) begin
         beat_in = BEAT_ECHO;
      end else if (load) begin
         beat_in = beat_ff + 1'b1;
      end
      valid_in = load || (valid_ff && !rsp_ready);
      out_in   = load ? sel : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= BEAT_ECHO;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

   `CRC16FE_ASSERT_IMP(a_mid_op_held, clock, reset, beat_ff != BEAT_ECHO, head_valid && head.append_crc)

endmodule
`default_nettype wire

/* sim/tb_crc16_command_frame_engine_top.sv */
// testbench for the crc16 command frame engine: queued beats, predicted results, flow control
`default_nettype none
module tb_crc16_command_frame_engine_top;
   timeunit 1ns;
   timeprecision 1ps;
   import crc16fe_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = CSR_INDEX_W'(3);
   localparam int RANDOM_ITEMS = 80;
   localparam int PHASE_ITEMS  = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   logic clock;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   crc16_command_frame_engine_top dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   req_type pending_beats[$];
   rsp_type expected_beats[$];
   int beats_queued = 0;
   int beats_taken = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit beat_taken = 1'b0;
   bit rsp_hold = 1'b0;
   bit pressure_go = 1'b0;

   // frame engine model state
   logic dir_mode = DIR_TX;
   int max_len = int'(MAX_FRAME_RST);
   logic [CRC_W-1:0] run_crc = '0;
   int frame_pos = 0;
   int frame_len = 0;
   bit crc_bad = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c,
                                                 input logic [DATA_W-1:0] b);
      logic fb;
      for (int i = 0; i < DATA_W; i++) begin
         fb = b[i] ^ c[CRC_W-1];
         c = {c[CRC_W-2:0], 1'b0};
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic void clear_frame_state();
      run_crc = '0;
      frame_pos = 0;
      frame_len = 0;
      crc_bad = 1'b0;
   endfunction

   function automatic void push_result(input logic [DATA_W-1:0] b, input logic last,
                                       input logic [STATUS_W-1:0] st);
      rsp_type r;
      r.out_byte = b;
      r.run_last = last;
      r.frame_status = st;
      expected_beats.push_back(r);
   endfunction

   function automatic void predict_results(input req_type r);
      logic [STATUS_W-1:0] st;
      st = ST_BUSY;
      if (dir_mode == DIR_TX) begin
         run_crc = crc_step(run_crc, r.data_byte);
         if (!r.end_of_payload) begin
            push_result(r.data_byte, 1'b1, ST_BUSY);
         end else begin
            push_result(r.data_byte, 1'b0, ST_BUSY);
            push_result(run_crc[7:0], 1'b0, ST_BUSY);
            push_result(run_crc[15:8], 1'b1, ST_BUSY);
            run_crc = '0;
         end
      end else begin
         if (frame_pos == 0) begin
            if (r.data_byte < MIN_COUNT) begin
               st = ST_COUNT_LOW;
            end else begin
               frame_len = int'(r.data_byte);
               run_crc = crc_step(run_crc, r.data_byte);
               frame_pos = 1;
            end
         end else if (frame_pos >= max_len) begin
            st = ST_OVERFLOW;
         end else if (frame_pos + 2 < frame_len) begin
            run_crc = crc_step(run_crc, r.data_byte);
            frame_pos++;
         end else if (frame_pos + 2 == frame_len) begin
            if (r.data_byte != run_crc[7:0]) crc_bad = 1'b1;
            frame_pos++;
         end else begin
            if (r.data_byte != run_crc[15:8]) crc_bad = 1'b1;
            st = crc_bad ? ST_CRC_BAD : ST_OK;
         end
         if (st != ST_BUSY) clear_frame_state();
         push_result(r.data_byte, 1'b1, st);
      end
   endfunction

   function automatic void queue_beat(input logic [DATA_W-1:0] b, input logic eop);
      req_type r;
      r.data_byte = b;
      r.end_of_payload = eop;
      pending_beats.push_back(r);
      beats_queued++;
   endfunction

   function automatic void queue_tx_frame(input int len);
      for (int i = 1; i <= len; i++) queue_beat(8'($urandom_range(255)), i == len);
   endfunction

   // send_len below the frame length truncates it
   function automatic void queue_rx_frame(input int count, input bit corrupt, input int send_len);
      logic [DATA_W-1:0] body[$];
      logic [CRC_W-1:0] c;
      int k;
      c = '0;
      body.push_back(8'(count));
      for (int i = 1; i < count - 2; i++) body.push_back(8'($urandom_range(255)));
      foreach (body[i]) c = crc_step(c, body[i]);
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
      if (corrupt) begin
         k = body.size() - 1 - int'($urandom_range(1));
         body[k] = body[k] ^ (8'h01 << $urandom_range(7));
      end
      for (int i = 0; i < send_len && i < body.size(); i++)
         queue_beat(body[i], 1'($urandom_range(1)));
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == REG_DIRECTION) begin
         dir_mode = val[0];
         clear_frame_state();
      end else if (idx == REG_MAX_FRAME) begin
         max_len = int'(val);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (beats_taken != beats_queued || expected_beats.size() != 0) @(negedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
         default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      beat_taken = 1'b0;
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_beat;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_results(req_data);
            beat_taken = 1'b1;
            beats_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result beat: byte %02h last %0b status %0d",
                           rsp_data.out_byte, rsp_data.run_last, rsp_data.frame_status);
            end else begin
               exp_beat = expected_beats.pop_front();
               if (rsp_data.out_byte !== exp_beat.out_byte ||
                   rsp_data.run_last !== exp_beat.run_last ||
                   rsp_data.frame_status !== exp_beat.frame_status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("result mismatch: expected %02h/%0b/%0d got %02h/%0b/%0d",
                              exp_beat.out_byte, exp_beat.run_last, exp_beat.frame_status,
                              rsp_data.out_byte, rsp_data.run_last, rsp_data.frame_status);
               end
            end
         end
      end
   end

   // long receiver hold-off so the queue fills and the input stalls
   initial begin
      wait (pressure_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int phase;
      int random_start;
      int phase_start;
      int pick;
      int cnt_hi;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: transmit extremes, then receive special cases
      queue_beat(8'h00, 1'b0);
      queue_beat(8'hFF, 1'b0);
      queue_beat(8'h5A, 1'b1);
      queue_beat(8'hFF, 1'b1);
      queue_beat(8'h00, 1'b1);
      wait_idle();
      write_reg(REG_DIRECTION, CSR_DATA_W'(DIR_RX));
      queue_rx_frame(3, 1'b0, 3);
      queue_rx_frame(5, 1'b0, 5);
      queue_rx_frame(4, 1'b1, 4);
      queue_beat(8'd0, 1'b0);
      queue_beat(8'd1, 1'b1);
      queue_beat(8'd2, 1'b0);
      wait_idle();
      write_reg(REG_MAX_FRAME, 8'd3);
      queue_rx_frame(6, 1'b0, 4);
      wait_idle();

      // longest frame at the largest limit
      write_reg(REG_DIRECTION, CSR_DATA_W'(DIR_RX));
      write_reg(REG_MAX_FRAME, 8'd255);
      queue_rx_frame(255, 1'b0, 255);
      wait_idle();

      random_start = beats_queued;
      phase = 0;
      while (phase < 4 || beats_queued - random_start < RANDOM_ITEMS) begin
         set_idling(phase % 4);
         if (phase == 0) begin
            write_reg(REG_DIRECTION, CSR_DATA_W'(DIR_TX));
         end else if ($urandom_range(3) != 0) begin
            write_reg(REG_DIRECTION, CSR_DATA_W'($urandom_range(1)));
         end
         pick = $urandom_range(7);
         case (pick)
            0: write_reg(REG_MAX_FRAME, 8'd3);
            1: write_reg(REG_MAX_FRAME, 8'd255);
            2: write_reg(REG_MAX_FRAME, 8'($urandom_range(2)));
            default: write_reg(REG_MAX_FRAME, 8'($urandom_range(40, 3)));
         endcase
         if (phase % 5 == 1) write_reg(REG_SPARE_2, 8'($urandom_range(255)));
         if (phase % 5 == 3) write_reg(REG_SPARE_3, 8'($urandom_range(255)));
         if (phase == 0) pressure_go = 1'b1;
         phase_start = beats_queued;
         while (beats_queued - phase_start < PHASE_ITEMS) begin
            if (dir_mode == DIR_TX) begin
               queue_tx_frame($urandom_range(8, 1));
            end else begin
               cnt_hi = (max_len < 12) ? 12 : max_len;
               if ($urandom_range(15) != 0 && cnt_hi > 12) cnt_hi = 12;
               pick = $urandom_range(9);
               case (pick)
                  0: queue_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
                  1: queue_rx_frame($urandom_range(cnt_hi, 3), 1'b1, 255);
                  2: queue_rx_frame($urandom_range(cnt_hi, 3), 1'b0, $urandom_range(4, 1));
                  default: queue_rx_frame($urandom_range(cnt_hi, 3), 1'b0, 255);
               endcase
            end
         end
         wait_idle();
         phase++;
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
